// ----- design/lurl_pkg.sv -----
package lurl_pkg;

   // field widths fixed by the stream format
   localparam int CH_W  = 7;
   localparam int LEN_W = 16;
   localparam int CH_CODES = 1 << CH_W;

   // default geometry
   localparam int ALPHABET_DEF = 128;
   localparam int POS_BITS_DEF = 16;

   // saturation value for the reported length
   localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

   // item kind codes
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic            kind;
      logic [CH_W-1:0] ch;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] longest;
      logic             too_long;
   } rsp_type;

   // control of the item in the table-read stage
   typedef struct packed {
      logic valid;
      logic is_end;
   } stage_ctrl_type;

   // finished result leaving the tracker
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

   // character code to table index, folded into the alphabet
   typedef logic [7:0] fold_table_type [CH_CODES];

   function automatic fold_table_type build_fold(input int alph);
      fold_table_type t;
      int r;
      r = 0;
      for (int i = 0; i < CH_CODES; i++) begin
         t[i] = 8'(r);
         if (r + 1 >= alph) begin
            r = 0;
         end else begin
            r = r + 1;
         end
      end
      return t;
   endfunction

endpackage

// ----- design/lurl_ram.sv -----
module lurl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lurl_track.sv -----
module lurl_track import lurl_pkg::*; #(
   parameter int ALPHABET = ALPHABET_DEF,
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  stage_ctrl_type               s1_ctrl,
   input  logic [$clog2(ALPHABET)-1:0]  s1_idx,
   input  logic                         fire,
   input  logic [POS_BITS-1:0]          rd_pos,
   output logic                         wr_en,
   output logic [$clog2(ALPHABET)-1:0]  wr_addr,
   output logic [POS_BITS-1:0]          wr_data,
   output done_type                     done
);

   localparam int IDX_W = $clog2(ALPHABET);
   localparam int LEN_CALC_W = POS_BITS + 1;
   localparam int CMP_W = (LEN_CALC_W > LEN_W + 1) ? LEN_CALC_W : LEN_W + 1;

   logic [POS_BITS:0]    pos_ff, pos_in;
   logic [POS_BITS-1:0]  wl_ff, wl_in;
   logic [LEN_W-1:0]     best_ff, best_in;
   logic                 ovf_ff, ovf_in;
   logic [ALPHABET-1:0]  seen_ff, seen_in;
   logic                 fwd_vld_ff, fwd_vld_in;
   logic [IDX_W-1:0]     fwd_idx_ff, fwd_idx_in;
   logic [POS_BITS-1:0]  fwd_pos_ff, fwd_pos_in;

   logic                 in_range;
   logic                 char_do;
   logic                 hit;
   logic [POS_BITS-1:0]  cur_pos;
   logic [POS_BITS-1:0]  prev_pos;
   logic [POS_BITS-1:0]  wl_new;
   logic [POS_BITS:0]    len;
   logic [CMP_W-1:0]     len_ext;
   logic [LEN_W-1:0]     len_sat;

   // window arithmetic for the character in this stage
   always_comb begin
      in_range = ~pos_ff[POS_BITS];
      cur_pos  = pos_ff[POS_BITS-1:0];
      char_do  = fire && (s1_ctrl.is_end == KIND_CHAR) && in_range;
      // last cycle's write has not reached the read data yet
      prev_pos = (fwd_vld_ff && (fwd_idx_ff == s1_idx)) ? fwd_pos_ff : rd_pos;
      hit      = seen_ff[s1_idx] && (prev_pos >= wl_ff);
      wl_new   = hit ? prev_pos + 1'b1 : wl_ff;
      len      = {1'b0, cur_pos} - {1'b0, wl_new} + 1'b1;
      len_ext  = CMP_W'(len);
      len_sat  = (len_ext > CMP_W'(LEN_MAX)) ? LEN_MAX : len_ext[LEN_W-1:0];
   end

   // next state of the string tracker
   always_comb begin
      pos_in  = pos_ff;
      wl_in   = wl_ff;
      best_in = best_ff;
      ovf_in  = ovf_ff;
      seen_in = seen_ff;
      if (fire && (s1_ctrl.is_end == KIND_END)) begin
         pos_in  = '0;
         wl_in   = '0;
         best_in = '0;
         ovf_in  = 1'b0;
         seen_in = '0;
      end else if (char_do) begin
         pos_in          = pos_ff + 1'b1;
         wl_in           = wl_new;
         seen_in[s1_idx] = 1'b1;
         if (len_sat > best_ff) begin
            best_in = len_sat;
         end
      end else if (fire) begin
         ovf_in = 1'b1;
      end
   end

   // forwarding of the write just made
   always_comb begin
      fwd_vld_in = char_do;
      fwd_idx_in = s1_idx;
      fwd_pos_in = cur_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wl_ff      <= '0;
         best_ff    <= '0;
         ovf_ff     <= 1'b0;
         seen_ff    <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wl_ff      <= wl_in;
         best_ff    <= best_in;
         ovf_ff     <= ovf_in;
         seen_ff    <= seen_in;
         fwd_vld_ff <= fwd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_idx_ff <= fwd_idx_in;
      fwd_pos_ff <= fwd_pos_in;
   end

   // table write-back and result
   assign wr_en   = char_do;
   assign wr_addr = s1_idx;
   assign wr_data = cur_pos;

   always_comb begin
      done.valid        = fire && (s1_ctrl.is_end == KIND_END);
      done.rsp.longest  = best_ff;
      done.rsp.too_long = ovf_ff;
   end

endmodule

// ----- design/longest_unique_run_length.sv -----
// Longest run without a repeated character. Characters stream in one per
// req transfer (kind = char); an end item (kind = end) returns the longest
// repeat-free window length of the string and a too_long flag, then starts a
// fresh string, so an empty string reports 0. The block takes one item every
// cycle: each character does one read-modify-write of the last-position table
// (a one-port-read, one-port-write RAM), with the previous cycle's write
// forwarded around the RAM's registered read. An end item passes the
// table-read stage and then the output register before its result is on
// rsp. Input stalls only when an end item reaches the table stage while an
// earlier result still waits on rsp. Lengths saturate at 65535; characters
// past position 2^POS_BITS - 1 are dropped and flagged. No clearing pass is
// needed after reset.
module longest_unique_run_length import lurl_pkg::*; #(
   parameter int ALPHABET = ALPHABET_DEF,
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(ALPHABET);
   localparam fold_table_type FOLD_TABLE = build_fold(ALPHABET);

   logic                 accept;
   logic                 stall;
   logic [IDX_W-1:0]     req_idx;
   stage_ctrl_type       s1_ctrl_ff, s1_ctrl_in;
   logic [IDX_W-1:0]     s1_idx_ff, s1_idx_in;
   logic                 fire;
   logic [POS_BITS-1:0]  rd_pos;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [POS_BITS-1:0]  wr_data;
   done_type             done;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // hold an end item while the output register is still occupied
   always_comb begin
      stall     = s1_ctrl_ff.valid && (s1_ctrl_ff.is_end == KIND_END)
                  && rsp_valid_ff && !rsp_ready;
      req_ready = !stall;
      accept    = req_valid && req_ready;
      fire      = s1_ctrl_ff.valid && !stall;
      req_idx   = FOLD_TABLE[req_data.ch][IDX_W-1:0];
   end

   // table-read stage
   always_comb begin
      s1_ctrl_in = s1_ctrl_ff;
      s1_idx_in  = s1_idx_ff;
      if (!stall) begin
         s1_ctrl_in.valid  = accept;
         s1_ctrl_in.is_end = req_data.kind;
         s1_idx_in         = req_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= s1_idx_in;
   end

   // last position of each character
   lurl_ram #(
      .WIDTH (POS_BITS),
      .DEPTH (ALPHABET)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_pos)
   );

   lurl_track #(
      .ALPHABET (ALPHABET),
      .POS_BITS (POS_BITS)
   ) u_track (
      .clock   (clock),
      .reset   (reset),
      .s1_ctrl (s1_ctrl_ff),
      .s1_idx  (s1_idx_ff),
      .fire    (fire),
      .rd_pos  (rd_pos),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .done    (done)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/lurl_checker.sv -----
module lurl_checker import lurl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a pending result stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   // a pending result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed before transfer");

   // input backpressure only comes from a blocked result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a blocked result");

   // a new result follows an accepted end transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && (req_data.kind == KIND_END), 2))
      else $error("result without an end item");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind longest_unique_run_length lurl_checker u_lurl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
